// File: src/rwsb_pkg.sv
`default_nettype none
package rwsb_pkg;

    // fixed-point format
    localparam int FRAC_BITS_DEF = 24;
    localparam int VAL_W         = 64;   // internal signed width, holds +/-2^61
    localparam int C_W           = 25;
    localparam int U_W           = 32;
    localparam int G_W           = 32;
    localparam int UP_W          = 25;
    localparam int LO_W          = 26;

    // saturation magnitude of every internal value
    localparam logic signed [VAL_W-1:0] SAT_MAG = 64'sd1 <<< 61;

    // per-lane results handed to the merging stage
    typedef struct packed {
        logic signed [VAL_W-1:0] plus;
        logic signed [VAL_W-1:0] minus;
    } lane_res_t;

    // clamp a signed 65-bit sum to the saturation magnitude
    function automatic logic signed [VAL_W-1:0] sat65(input logic signed [VAL_W:0] x);
        logic signed [VAL_W:0] mx;
        mx = {1'b0, SAT_MAG};
        if (x > mx)
            return SAT_MAG;
        else if (x < -mx)
            return -SAT_MAG;
        else
            return x[VAL_W-1:0];
    endfunction

endpackage
`default_nettype wire

// File: src/rwsb_mul.sv
`default_nettype none
// registered fixed-point multiply of two magnitudes with sign, result
// shifted down by the fraction bits and saturated; operands up to 62 bits are
// split into 31-bit partial products summed over two register stages
module rwsb_mul #(
    parameter int FRACTION_BITS = rwsb_pkg::FRAC_BITS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              en,
    input  wire logic [61:0]                       a_mag,
    input  wire logic [61:0]                       b_mag,
    input  wire logic                              neg,
    output logic signed [rwsb_pkg::VAL_W-1:0]      p
);
    import rwsb_pkg::*;

    logic [61:0]  pp00_reg, pp01_reg, pp10_reg, pp11_reg;
    logic [61:0]  pp00_next, pp01_next, pp10_next, pp11_next;
    logic         neg_reg;
    logic [123:0] full;
    logic [123:0] shifted;
    logic [VAL_W-1:0] mag;

    // partial products
    always_comb
    begin
        pp00_next = {31'd0, a_mag[30:0]} * {31'd0, b_mag[30:0]};
        pp01_next = {31'd0, a_mag[30:0]} * {31'd0, b_mag[61:31]};
        pp10_next = {31'd0, a_mag[61:31]} * {31'd0, b_mag[30:0]};
        pp11_next = {31'd0, a_mag[61:31]} * {31'd0, b_mag[61:31]};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pp00_reg <= pp00_next;
            pp01_reg <= pp01_next;
            pp10_reg <= pp10_next;
            pp11_reg <= pp11_next;
            neg_reg  <= neg;
        end
    end

    // sum, scale and saturate
    always_comb
    begin
        full = {62'd0, pp00_reg} + ({62'd0, pp01_reg} << 31) + ({62'd0, pp10_reg} << 31)
             + ({62'd0, pp11_reg} << 62);
        shifted = full >> FRACTION_BITS;
        if (shifted > {60'd0, SAT_MAG})
            mag = SAT_MAG;
        else
            mag = shifted[VAL_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            p <= neg_reg ? -$signed(mag) : $signed(mag);
    end

endmodule
`default_nettype wire

// File: src/rwsb_sqrt.sv
`default_nettype none
// pipelined digit-recurrence square root: floor(sqrt(b << FRACTION_BITS)),
// two radicand bits and one root bit per stage, compare and subtract only
module rwsb_sqrt #(
    parameter int FRACTION_BITS = rwsb_pkg::FRAC_BITS_DEF,
    parameter int PASS_W        = 64
) (
    input  wire logic                   clk,
    input  wire logic                   en,
    input  wire logic [61:0]            b,
    input  wire logic [PASS_W-1:0]      pass_in,
    output logic [52:0]                 root,
    output logic [PASS_W-1:0]           pass_out
);
    localparam int STEPS = 53;
    localparam int RAD_W = 2 * STEPS;
    localparam int REM_W = STEPS + 3;

    logic [RAD_W-1:0]  rad_reg  [STEPS+1];
    logic [REM_W-1:0]  rem_reg  [STEPS+1];
    logic [52:0]       r_reg    [STEPS+1];
    logic [PASS_W-1:0] pass_reg [STEPS+1];

    // stage zero loads the radicand
    always_comb
    begin
        rad_reg[0]  = {44'd0, b} << FRACTION_BITS;
        rem_reg[0]  = '0;
        r_reg[0]    = '0;
        pass_reg[0] = pass_in;
    end

    // one result bit per stage, most significant first
    for (genvar s = 0; s < STEPS; s++)
    begin : g_step
        logic [REM_W-1:0] rem_sh;
        logic [REM_W-1:0] trial;
        logic             qb;
        always_comb
        begin
            rem_sh = {rem_reg[s][REM_W-3:0], rad_reg[s][2*(STEPS-1-s) +: 2]};
            trial  = {1'b0, r_reg[s], 2'b01};
            qb     = (rem_sh >= trial);
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rad_reg[s+1]  <= rad_reg[s];
                rem_reg[s+1]  <= qb ? rem_sh - trial : rem_sh;
                r_reg[s+1]    <= {r_reg[s][51:0], qb};
                pass_reg[s+1] <= pass_reg[s];
            end
        end
    end

    assign root     = r_reg[STEPS];
    assign pass_out = pass_reg[STEPS];

endmodule
`default_nettype wire

// File: src/rwsb_div.sv
`default_nettype none
// pipelined restoring divider: (n << FRACTION_BITS) / d, truncated, saturated
module rwsb_div #(
    parameter int FRACTION_BITS = rwsb_pkg::FRAC_BITS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              en,
    input  wire logic signed [rwsb_pkg::VAL_W-1:0] n,
    input  wire logic signed [rwsb_pkg::VAL_W-1:0] d,
    output logic signed [rwsb_pkg::VAL_W-1:0]      q
);
    import rwsb_pkg::*;

    localparam int STEPS = 128;

    logic [127:0] num_reg [STEPS+1];
    logic [63:0]  den_reg [STEPS+1];
    logic [64:0]  rem_reg [STEPS+1];
    logic [63:0]  quo_reg [STEPS+1];
    logic         neg_reg [STEPS+1];
    logic         zero_reg [STEPS+1];
    logic         nz_reg  [STEPS+1];
    logic [63:0]  mn;

    always_comb
    begin
        mn          = n[VAL_W-1] ? 64'(-n) : 64'(n);
        num_reg[0]  = {64'd0, mn} << FRACTION_BITS;
        den_reg[0]  = 64'(d);
        rem_reg[0]  = '0;
        quo_reg[0]  = '0;
        neg_reg[0]  = n[VAL_W-1];
        zero_reg[0] = (d == '0);
        nz_reg[0]   = (n != '0);
    end

    // one quotient bit per stage, quotient saturating at the limit
    for (genvar s = 0; s < STEPS; s++)
    begin : g_step
        logic [64:0] r1;
        logic        qb;
        logic [64:0] r2;
        logic [63:0] qn;
        always_comb
        begin
            r1 = {rem_reg[s][63:0], num_reg[s][STEPS-1-s]};
            qb = (r1 >= {1'b0, den_reg[s]});
            r2 = qb ? r1 - {1'b0, den_reg[s]} : r1;
            if (quo_reg[s] >= 64'(SAT_MAG))
                qn = 64'(SAT_MAG);
            else
                qn = {quo_reg[s][62:0], qb};
            if (qn > 64'(SAT_MAG))
                qn = 64'(SAT_MAG);
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                num_reg[s+1]  <= num_reg[s];
                den_reg[s+1]  <= den_reg[s];
                rem_reg[s+1]  <= r2;
                quo_reg[s+1]  <= qn;
                neg_reg[s+1]  <= neg_reg[s];
                zero_reg[s+1] <= zero_reg[s];
                nz_reg[s+1]   <= nz_reg[s];
            end
        end
    end

    // sign and zero-denominator handling
    always_comb
    begin
        if (zero_reg[STEPS])
            q = nz_reg[STEPS] ? (neg_reg[STEPS] ? -SAT_MAG : SAT_MAG) : '0;
        else
            q = neg_reg[STEPS] ? -$signed(quo_reg[STEPS]) : $signed(quo_reg[STEPS]);
    end

endmodule
`default_nettype wire

// File: src/rwsb_lane.sv
`default_nettype none
// one side of the interface: coefficients, root and both wave speeds
module rwsb_lane #(
    parameter int FRACTION_BITS = rwsb_pkg::FRAC_BITS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              en,
    input  wire logic [rwsb_pkg::C_W-1:0]          c_in,
    input  wire logic signed [rwsb_pkg::U_W-1:0]   u_in,
    input  wire logic [rwsb_pkg::G_W-1:0]          g_in,
    output rwsb_pkg::lane_res_t                    res
);
    import rwsb_pkg::*;

    localparam logic [61:0] ONE = 62'd1 << FRACTION_BITS;

    // stage 0: clamp and magnitudes
    logic [61:0] c_reg, omc_reg, ua_reg, g_reg;
    logic        un_reg;
    logic [61:0] c_next;
    always_comb
        c_next = ({37'd0, c_in} > ONE) ? ONE : {37'd0, c_in};
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_reg   <= c_next;
            omc_reg <= ONE - c_next;
            ua_reg  <= u_in[U_W-1] ? 62'(-{{30{u_in[U_W-1]}}, u_in}) : 62'(u_in);
            un_reg  <= u_in[U_W-1];
            g_reg   <= {30'd0, g_in};
        end
    end

    // stage 1: g^2, u^2, g*u
    logic signed [VAL_W-1:0] g2, u2, gu;
    rwsb_mul #(.FRACTION_BITS(FRACTION_BITS)) u_g2
        (.clk, .en, .a_mag(g_reg), .b_mag(g_reg), .neg(1'b0), .p(g2));
    rwsb_mul #(.FRACTION_BITS(FRACTION_BITS)) u_u2
        (.clk, .en, .a_mag(ua_reg), .b_mag(ua_reg), .neg(1'b0), .p(u2));
    rwsb_mul #(.FRACTION_BITS(FRACTION_BITS)) u_gu
        (.clk, .en, .a_mag(g_reg), .b_mag(ua_reg), .neg(1'b0), .p(gu));
    logic [61:0] c_d1, c_d2, omc_d1, omc_d2;
    logic        un_d1, un_d2;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_d1 <= c_reg; c_d2 <= c_d1;
            omc_d1 <= omc_reg; omc_d2 <= omc_d1;
            un_d1 <= un_reg; un_d2 <= un_d1;
        end
    end

    // stage 2: diff and t, register
    logic signed [VAL_W-1:0] diff_reg, t_reg, g2_reg, gu_reg;
    logic [61:0] c_d3, omc_d3;
    logic        un_d3;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            diff_reg <= g2 - u2;
            t_reg    <= sat65(65'(g2 - u2) - 65'($signed({2'b0, ONE})));
            g2_reg   <= g2;
            gu_reg   <= gu;
            c_d3     <= c_d2;
            omc_d3   <= omc_d2;
            un_d3    <= un_d2;
        end
    end

    // stage 3: t*c, a, g2*(1-c)
    logic signed [VAL_W-1:0] tc, am, g2omc;
    logic [61:0] t_mag;
    assign t_mag = t_reg[VAL_W-1] ? 62'(-t_reg) : 62'(t_reg);
    rwsb_mul #(.FRACTION_BITS(FRACTION_BITS)) u_tc
        (.clk, .en, .a_mag(t_mag), .b_mag(c_d3), .neg(t_reg[VAL_W-1] && c_d3 != '0), .p(tc));
    rwsb_mul #(.FRACTION_BITS(FRACTION_BITS)) u_am
        (.clk, .en, .a_mag(62'(gu_reg)), .b_mag(omc_d3), .neg(un_d3), .p(am));
    rwsb_mul #(.FRACTION_BITS(FRACTION_BITS)) u_gd
        (.clk, .en, .a_mag(62'(g2_reg)), .b_mag(omc_d3), .neg(1'b0), .p(g2omc));
    logic signed [VAL_W-1:0] diff_d1, diff_d2;
    logic [61:0] c_d4, c_d5;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            diff_d1 <= diff_reg; diff_d2 <= diff_d1;
            c_d4 <= c_d3; c_d5 <= c_d4;
        end
    end

    // stage 4: inner, d
    logic signed [VAL_W-1:0] inner_reg, d_reg, a_reg;
    logic [61:0] c_d6;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            inner_reg <= sat65(65'(diff_d2) - 65'(tc));
            d_reg     <= sat65(65'(g2omc) + 65'($signed({2'b0, c_d5})));
            a_reg     <= am;
            c_d6      <= c_d5;
        end
    end

    // stage 5: b = inner*c
    logic signed [VAL_W-1:0] bval;
    logic [61:0] in_mag;
    assign in_mag = inner_reg[VAL_W-1] ? 62'(-inner_reg) : 62'(inner_reg);
    rwsb_mul #(.FRACTION_BITS(FRACTION_BITS)) u_b
        (.clk, .en, .a_mag(in_mag), .b_mag(c_d6),
         .neg(inner_reg[VAL_W-1] && c_d6 != '0), .p(bval));
    logic signed [VAL_W-1:0] a_d1, a_d2, d_d1, d_d2;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_d1 <= a_reg; a_d2 <= a_d1;
            d_d1 <= d_reg; d_d2 <= d_d1;
        end
    end

    // square root with a and d carried alongside
    logic [61:0]  b_clamped;
    logic [52:0]  root;
    logic [127:0] pass_out;
    assign b_clamped = bval[VAL_W-1] ? '0 : 62'(bval);
    rwsb_sqrt #(.FRACTION_BITS(FRACTION_BITS), .PASS_W(128)) u_sqrt
        (.clk, .en, .b(b_clamped), .pass_in({a_d2, d_d2}), .root, .pass_out);

    // numerators
    logic signed [VAL_W-1:0] np_reg, nm_reg, dd_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            np_reg <= $signed(pass_out[127:64]) + $signed({11'd0, root});
            nm_reg <= $signed(pass_out[127:64]) - $signed({11'd0, root});
            dd_reg <= $signed(pass_out[63:0]);
        end
    end

    rwsb_div #(.FRACTION_BITS(FRACTION_BITS)) u_dp
        (.clk, .en, .n(np_reg), .d(dd_reg), .q(res.plus));
    rwsb_div #(.FRACTION_BITS(FRACTION_BITS)) u_dm
        (.clk, .en, .n(nm_reg), .d(dd_reg), .q(res.minus));

endmodule
`default_nettype wire

// File: src/relativistic_wave_speed_bounds_core.sv
`default_nettype none
// channel | signals                                    | direction
// in      | valid, stall, six fluid fields             | into block
// out     | out_valid, out_stall, bounds and flag      | out of block
// cfg     | cfg_valid, cfg_ready, cfg_data             | into block
//
// one transaction per cycle while the pipeline is not stalled; a result passes
// through the product and sum stages, 53 root stages, one numerator stage and
// 128 divider stages, then the output register
// the whole pipeline advances when the output register is free or taken;
// out_stall with out_valid set halts all stages, and input stall follows it
// reset clears the valid chain, out_valid and the mode register
module relativistic_wave_speed_bounds_core #(
    parameter int FRACTION_BITS = rwsb_pkg::FRAC_BITS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              valid,
    output logic                                   stall,
    input  wire logic [rwsb_pkg::C_W-1:0]          sound_speed_sq_left,
    input  wire logic signed [rwsb_pkg::U_W-1:0]   normal_velocity_left,
    input  wire logic [rwsb_pkg::G_W-1:0]          lorentz_factor_left,
    input  wire logic [rwsb_pkg::C_W-1:0]          sound_speed_sq_right,
    input  wire logic signed [rwsb_pkg::U_W-1:0]   normal_velocity_right,
    input  wire logic [rwsb_pkg::G_W-1:0]          lorentz_factor_right,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic [rwsb_pkg::UP_W-1:0]              speed_upper,
    output logic signed [rwsb_pkg::LO_W-1:0]       speed_lower,
    output logic                                   superluminal,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic                              cfg_data
);
    import rwsb_pkg::*;

    localparam int DEPTH = 1 + 2 + 1 + 2 + 1 + 2 + 53 + 1 + 128;
    localparam logic signed [VAL_W-1:0] ONE_FX = 64'sd1 <<< FRACTION_BITS;
    localparam logic signed [VAL_W-1:0] LIGHT =
        VAL_W'(((64'd101 << FRACTION_BITS) + 64'd50) / 64'd100);
    localparam logic signed [VAL_W-1:0] UP_MAX = 64'sd33554431;
    localparam logic signed [VAL_W-1:0] LO_MIN = -64'sd33554432;

    logic en;
    logic mode_reg;
    logic vld_reg [DEPTH];
    lane_res_t res_l, res_r;

    assign en        = !out_valid || !out_stall;
    assign stall     = !en;
    assign cfg_ready = 1'b1;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= 1'b0;
        else if (cfg_valid && cfg_ready)
            mode_reg <= cfg_data;
    end

    // valid chain alongside the lanes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
                vld_reg[i] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= valid;
            for (int i = 1; i < DEPTH; i++)
                vld_reg[i] <= vld_reg[i-1];
        end
    end

    rwsb_lane #(.FRACTION_BITS(FRACTION_BITS)) u_left
        (.clk, .en, .c_in(sound_speed_sq_left), .u_in(normal_velocity_left),
         .g_in(lorentz_factor_left), .res(res_l));
    rwsb_lane #(.FRACTION_BITS(FRACTION_BITS)) u_right
        (.clk, .en, .c_in(sound_speed_sq_right), .u_in(normal_velocity_right),
         .g_in(lorentz_factor_right), .res(res_r));

    // merge lanes, apply light-speed mode and saturate
    logic signed [VAL_W-1:0] up, lo;
    logic                    flag;
    always_comb
    begin
        up = (res_l.plus > res_r.plus) ? res_l.plus : res_r.plus;
        if (up < 0)
            up = '0;
        lo = (res_l.minus < res_r.minus) ? res_l.minus : res_r.minus;
        if (lo > 0)
            lo = '0;
        flag = (up > ONE_FX) || (lo < -ONE_FX);
        if (mode_reg)
        begin
            up   = LIGHT;
            lo   = -LIGHT;
            flag = 1'b0;
        end
        if (up > UP_MAX)
            up = UP_MAX;
        if (lo < LO_MIN)
            lo = LO_MIN;
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid <= 1'b0;
        else if (en)
            out_valid <= vld_reg[DEPTH-1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            speed_upper  <= up[UP_W-1:0];
            speed_lower  <= lo[LO_W-1:0];
            superluminal <= flag;
        end
    end

endmodule
`default_nettype wire

// File: verif/wave_bounds_checker.sv
`timescale 1ns / 1ps
module wave_bounds_checker
    import rwsb_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 valid,
    input  wire logic                 stall,
    input  wire logic [C_W-1:0]       sound_speed_sq_left,
    input  wire logic signed [U_W-1:0] normal_velocity_left,
    input  wire logic [G_W-1:0]       lorentz_factor_left,
    input  wire logic [C_W-1:0]       sound_speed_sq_right,
    input  wire logic signed [U_W-1:0] normal_velocity_right,
    input  wire logic [G_W-1:0]       lorentz_factor_right,
    input  wire logic                 out_valid,
    input  wire logic                 out_stall,
    input  wire logic [UP_W-1:0]      speed_upper,
    input  wire logic signed [LO_W-1:0] speed_lower,
    input  wire logic                 superluminal,
    input  wire logic                 cfg_valid,
    input  wire logic                 cfg_ready,
    input  wire logic                 cfg_data,
    output int                        fail_count,
    output int                        pending
);

    localparam int FB = FRAC_BITS_DEF;
    localparam longint ONE = longint'(1) << FB;
    localparam longint SATV = longint'(1) << 61;
    localparam longint LIGHT = ((longint'(101) << FB) + 50) / 100;
    localparam longint UPPER_MAX = 33554431;
    localparam longint LOWER_MIN = -33554432;

    typedef struct packed {
        logic [UP_W-1:0]        upper;
        logic signed [LO_W-1:0] lower;
        logic                   flag;
    } bounds_t;

    bounds_t bounds_q[$];
    logic    light_mode;

    // truncated fixed-point product of magnitudes, saturated
    function automatic longint mag_mul(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = ({64'b0, a} * {64'b0, b}) >> FB;
        if (p > 128'(SATV))
            return SATV;
        return longint'(p[63:0]);
    endfunction

    function automatic longint sat(input longint x);
        if (x > SATV)
            return SATV;
        if (x < -SATV)
            return -SATV;
        return x;
    endfunction

    function automatic longint signed_mul(input longint a, input longint b);
        longint m;
        m = mag_mul(a < 0 ? -a : a, b < 0 ? -b : b);
        return ((a < 0) != (b < 0)) ? -m : m;
    endfunction

    // floor of the fixed-point square root
    function automatic longint fx_root(input longint b);
        logic [127:0] n;
        logic [127:0] r;
        logic [127:0] cand;
        n = {64'b0, b} << FB;
        r = 0;
        for (int i = 52; i >= 0; i--)
        begin
            cand = r | (128'd1 << i);
            if (cand * cand <= n)
                r = cand;
        end
        return longint'(r[63:0]);
    endfunction

    // truncated fixed-point quotient, saturated; zero divisor by sign
    function automatic longint fx_quot(input longint n, input longint d);
        logic [127:0] q;
        if (d == 0)
            return n > 0 ? SATV : (n < 0 ? -SATV : 0);
        q = ({64'b0, n < 0 ? -n : n} << FB) / {64'b0, d};
        if (q > 128'(SATV))
            q = 128'(SATV);
        return n < 0 ? -longint'(q[63:0]) : longint'(q[63:0]);
    endfunction

    // both wave speeds of one side of the interface
    function automatic void side_speeds(input logic [C_W-1:0] cin,
                                        input logic signed [U_W-1:0] u,
                                        input logic [G_W-1:0] g,
                                        output longint plus, output longint minus);
        longint c, omc, ua, g2, u2, am, a, diff, t, inner, b, d, s;
        c = (cin > ONE) ? ONE : longint'(cin);
        omc = ONE - c;
        ua = (u < 0) ? -longint'(u) : longint'(u);
        g2 = mag_mul({32'b0, g}, {32'b0, g});
        u2 = mag_mul(ua, ua);
        am = mag_mul(mag_mul({32'b0, g}, ua), omc);
        a = (u < 0) ? -am : am;
        diff = g2 - u2;
        t = sat(diff - ONE);
        inner = sat(diff - signed_mul(t, c));
        b = signed_mul(inner, c);
        d = sat(mag_mul(g2, omc) + c);
        if (b < 0)
            b = 0;
        s = fx_root(b);
        plus = fx_quot(a + s, d);
        minus = fx_quot(a - s, d);
    endfunction

    function automatic bounds_t predict_bounds(input logic mode);
        bounds_t r;
        longint up, lo, pl, ml, pr, mr;
        r.flag = 1'b0;
        if (mode)
        begin
            up = LIGHT;
            lo = -LIGHT;
        end
        else
        begin
            side_speeds(sound_speed_sq_left, normal_velocity_left, lorentz_factor_left,
                        pl, ml);
            side_speeds(sound_speed_sq_right, normal_velocity_right, lorentz_factor_right,
                        pr, mr);
            up = (pl > pr) ? pl : pr;
            if (up < 0)
                up = 0;
            lo = (ml < mr) ? ml : mr;
            if (lo > 0)
                lo = 0;
            r.flag = (up > ONE) || (lo < -ONE);
        end
        if (up > UPPER_MAX)
            up = UPPER_MAX;
        if (lo < LOWER_MIN)
            lo = LOWER_MIN;
        r.upper = up[UP_W-1:0];
        r.lower = lo[LO_W-1:0];
        return r;
    endfunction

    task automatic report(input string what, input longint got, input longint want);
        $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        fail_count++;
    endtask

    initial
    begin
        fail_count = 0;
        pending = 0;
        light_mode = 1'b0;
    end

    // track config, predict on input transactions, compare on output transactions
    always @(posedge clk)
    begin
        bounds_t e;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (bounds_q.size() == 0)
                    report("unexpected result", 0, 0);
                else
                begin
                    e = bounds_q.pop_front();
                    if (speed_upper !== e.upper)
                        report("speed_upper", speed_upper, e.upper);
                    if (speed_lower !== e.lower)
                        report("speed_lower", speed_lower, e.lower);
                    if (superluminal !== e.flag)
                        report("superluminal", superluminal, e.flag);
                end
            end
            if (valid && !stall)
                bounds_q.push_back(predict_bounds(light_mode));
            if (cfg_valid && cfg_ready)
                light_mode = cfg_data;
            pending = bounds_q.size();
        end
        else
            light_mode = 1'b0;
    end

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps
module testbench;
    import rwsb_pkg::*;

    localparam logic [U_W-1:0] ONE   = U_W'(1) << FRAC_BITS_DEF;
    localparam logic [C_W-1:0] C_ONE = C_W'(1) << FRAC_BITS_DEF;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic valid = 1'b0;
    logic stall;
    logic [C_W-1:0] c_l = '0;
    logic signed [U_W-1:0] u_l = '0;
    logic [G_W-1:0] g_l = '0;
    logic [C_W-1:0] c_r = '0;
    logic signed [U_W-1:0] u_r = '0;
    logic [G_W-1:0] g_r = '0;
    logic out_valid;
    logic out_stall = 1'b1;
    logic [UP_W-1:0] speed_upper;
    logic signed [LO_W-1:0] speed_lower;
    logic superluminal;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic cfg_data = 1'b0;
    int fail_count;
    int pending;
    bit idle_on = 1'b1;
    bit long_hold = 1'b0;

    relativistic_wave_speed_bounds_core u_top (
        .clk(clk), .rst_n(rst_n), .valid(valid), .stall(stall),
        .sound_speed_sq_left(c_l), .normal_velocity_left(u_l), .lorentz_factor_left(g_l),
        .sound_speed_sq_right(c_r), .normal_velocity_right(u_r), .lorentz_factor_right(g_r),
        .out_valid(out_valid), .out_stall(out_stall), .speed_upper(speed_upper),
        .speed_lower(speed_lower), .superluminal(superluminal),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    wave_bounds_checker u_checker (
        .clk(clk), .rst_n(rst_n), .valid(valid), .stall(stall),
        .sound_speed_sq_left(c_l), .normal_velocity_left(u_l), .lorentz_factor_left(g_l),
        .sound_speed_sq_right(c_r), .normal_velocity_right(u_r), .lorentz_factor_right(g_r),
        .out_valid(out_valid), .out_stall(out_stall), .speed_upper(speed_upper),
        .speed_lower(speed_lower), .superluminal(superluminal),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending(pending)
    );

    // clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // run limit
    initial
    begin
        #4000000;
        $display("Regression FAIL");
        $finish;
    end

    // output side: random or long hold-off per transaction
    initial
    begin
        int n;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            n = idle_on ? $urandom_range(0, 18) : 0;
            if (long_hold)
            begin
                n = 700;
                long_hold = 1'b0;
            end
            if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(negedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
            @(negedge clk);
        end
    end

    // one input transaction, then a random gap while idle_on is set
    task automatic send(input logic [C_W-1:0] cl, input logic [U_W-1:0] ul,
                        input logic [G_W-1:0] gl, input logic [C_W-1:0] cr,
                        input logic [U_W-1:0] ur, input logic [G_W-1:0] gr);
        int gap;
        c_l <= cl; u_l <= ul; g_l <= gl;
        c_r <= cr; u_r <= ur; g_r <= gr;
        valid <= 1'b1;
        do @(posedge clk); while (stall);
        @(negedge clk);
        gap = idle_on ? $urandom_range(0, 18) : 0;
        if (gap > 0)
        begin
            valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    // mostly physical states: g = sqrt(1 + u^2), sometimes raw bits
    task automatic rand_side(output logic [C_W-1:0] c, output logic [U_W-1:0] u,
                             output logic [G_W-1:0] g);
        real ur;
        int k;
        k = $urandom_range(0, 9);
        if (k < 7)
        begin
            ur = ($urandom_range(0, 1000000) / 500000.0 - 1.0) * (2.0 ** $urandom_range(0, 6));
            u = $rtoi(ur * ONE);
            g = $rtoi($sqrt(1.0 + ur * ur) * ONE) + $urandom_range(0, 3);
            c = C_W'($urandom_range(0, 1 << 24));
        end
        else
        begin
            u = $urandom;
            g = $urandom;
            c = C_W'($urandom);
        end
    endtask

    task automatic send_random(input int count);
        logic [C_W-1:0] cl, cr;
        logic [U_W-1:0] ul, ur;
        logic [G_W-1:0] gl, gr;
        repeat (count)
        begin
            rand_side(cl, ul, gl);
            rand_side(cr, ur, gr);
            send(cl, ul, gl, cr, ur, gr);
        end
    endtask

    // sender pause until all results are back, then pipeline flush
    task automatic drain();
        valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        repeat (260) @(negedge clk);
    endtask

    task automatic write_mode(input logic m);
        cfg_data <= m;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    initial
    begin
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        // directed: field extremes, sound speed above one, negative B, zero divisor
        write_mode(1'b0);
        send(0, 0, ONE, 0, 0, ONE);
        send(C_ONE, 0, ONE, C_ONE, 0, ONE);
        send(25'h1FFFFFF, 32'h7FFFFFFF, 32'hFFFFFFFF, 25'h1FFFFFF, 32'h80000000, 32'hFFFFFFFF);
        send(C_ONE / 3, 32'h80000000, ONE, C_ONE / 2, 32'h7FFFFFFF, ONE);
        send(C_ONE / 2, 32'h7FFFFFFF, ONE, C_ONE / 4, 32'h80000000, ONE);
        send(0, 0, 0, 0, 0, 0);
        send(0, ONE, 0, 0, -ONE, 0);
        send(C_ONE, 32'h80000000, 0, C_ONE, 32'h7FFFFFFF, 0);
        send(C_ONE / 3, ONE, 32'd23726566, C_ONE / 3, -ONE, 32'd23726566);
        send(C_ONE - 1, 32'h7FFFFFFF, 32'hFFFFFFFF, C_ONE + 1, 32'h80000000, ONE);
        send(C_ONE / 10, 8 * ONE, ONE, C_ONE / 10, -8 * ONE, ONE);
        send(25'h1000001, 1, 32'h00000001, 25'h0FFFFFF, -1, 32'h80000000);
        send(C_ONE / 3, 30 * ONE, 32'h7FFFFFFF, C_ONE / 3, -30 * ONE, 32'h7FFFFFFF);
        send(C_ONE / 3, 0, ONE, C_ONE / 3, 0, ONE);
        drain();

        // light-speed mode
        write_mode(1'b1);
        send(0, 0, ONE, C_ONE, 32'h7FFFFFFF, 32'hFFFFFFFF);
        send_random(100);
        drain();

        // computed mode with a long output hold-off
        write_mode(1'b0);
        send_random(150);
        long_hold = 1'b1;
        send_random(250);
        drain();

        write_mode(1'b1);
        send_random(80);
        drain();

        // back-to-back stretch
        write_mode(1'b0);
        idle_on = 1'b0;
        send_random(200);
        idle_on = 1'b1;
        send_random(220);
        drain();

        if (fail_count == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
